### src/rau_pkg.sv
// Package for the rational arithmetic unit.
// Holds opcode, status and sequencer state codes. No dependencies.
package rau_pkg;

    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 2;
    localparam int FIELD_W  = 32;
    localparam int DEN_W    = 31;

    localparam logic [OPCODE_W-1:0] OP_NORM = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_DIV  = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_NEG  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_COMB = 7'b0000100,
        S_GCD  = 7'b0001000,
        S_DIVN = 7'b0010000,
        S_DIVD = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

endpackage

### src/rau_if.sv
// Handshake channels of the rational arithmetic unit.
// Depends on rau_pkg for field widths.
interface rau_in_if import rau_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [FIELD_W-1:0]  a_num;
    logic signed [FIELD_W-1:0]  a_den;
    logic signed [FIELD_W-1:0]  b_num;
    logic signed [FIELD_W-1:0]  b_den;

    modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if import rau_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  res_num;
    logic [DEN_W-1:0]           res_den;
    logic [STATUS_W-1:0]        status;

    modport source (output valid, res_num, res_den, status, input ready);
    modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

### src/rau_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by rational_arithmetic_unit.
module rau_div #(
    parameter int DW = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW);

    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [DW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic          fits;

    always_comb
    begin
        trial    = {rem_reg[DW-1:0], quo_reg[DW-1]};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? (trial - {1'b0, dvs_reg}) : trial;
        quo_next = {quo_reg[DW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### src/rational_arithmetic_unit.sv
// Rational arithmetic unit top level.
// Depends on rau_pkg, rau_in_if/rau_out_if and rau_div.
//
// One item at a time: in_ch.ready is high only when the unit is idle. An
// item with a zero operand denominator goes straight from idle to the
// output state. Otherwise the shared WIDTHxWIDTH multiplier forms three
// products in turn (none for normalize and negate), a combine state forms
// numerator and denominator, the binary gcd loop takes one compare/subtract
// or shift per cycle on the 2*WIDTH-bit parts, and the shared divider then
// divides numerator and denominator by the gcd, one after the other. The
// result then waits in the output register until taken.
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input logic        clk,
    input logic        rst_n,
    rau_in_if.sink     in_ch,
    rau_out_if.source  out_ch
);

    localparam int DW = 2 * WIDTH;
    localparam logic [DW-1:0] LIMIT = DW'(1) << (WIDTH - 1);

    state_t state_reg, state_next;

    logic [OPCODE_W-1:0] op_reg;
    logic [WIDTH-1:0]    an_reg, ad_reg, bn_reg, bd_reg;
    logic                an_s_reg, ad_s_reg, bn_s_reg, bd_s_reg;
    logic [1:0]          cnt_reg;
    logic [DW-1:0]       p_reg [3];
    logic                ps_reg [3];
    logic [DW-1:0]       nn_reg, dd_reg, u_reg, v_reg, nq_reg;
    logic                neg_reg;
    logic signed [FIELD_W-1:0] rnum_reg;
    logic [DEN_W-1:0]    rden_reg;
    logic [STATUS_W-1:0] rst_reg;

    logic [WIDTH-1:0] in_an, in_ad, in_bn, in_bd;
    logic             in_binary, in_zero;
    logic             accept;

    logic [WIDTH-1:0] mx, my;
    logic             msx, msy;
    logic [DW-1:0]    prod;

    logic [DW-1:0] n_mag, d_mag, q1_mag;
    logic          n_neg, d_neg, q1_neg;

    logic          div_start, div_done;
    logic [DW-1:0] div_dividend, div_q;

    logic             ovf;
    logic signed [DW-1:0] sval;

    function automatic logic [WIDTH-1:0] mag_of(input logic [FIELD_W-1:0] raw);
        logic [WIDTH-1:0] v;
        v = raw[WIDTH-1:0];
        return v[WIDTH-1] ? WIDTH'(~v + 1'b1) : v;
    endfunction

    assign accept    = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);

    always_comb
    begin
        in_an     = mag_of(in_ch.a_num);
        in_ad     = mag_of(in_ch.a_den);
        in_bn     = mag_of(in_ch.b_num);
        in_bd     = mag_of(in_ch.b_den);
        in_binary = in_ch.opcode inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV};
        in_zero   = (in_ad == '0) || (in_binary && in_bd == '0);
    end

    // shared multiplier operand select
    always_comb
    begin
        case (cnt_reg)
            2'd0:
            begin
                mx  = an_reg;
                msx = an_s_reg;
                my  = (op_reg == OP_MUL) ? bn_reg : bd_reg;
                msy = (op_reg == OP_MUL) ? bn_s_reg : bd_s_reg;
            end
            2'd1:
            begin
                mx  = bn_reg;
                msx = bn_s_reg;
                my  = ad_reg;
                msy = ad_s_reg;
            end
            default:
            begin
                mx  = ad_reg;
                msx = ad_s_reg;
                my  = (op_reg == OP_DIV) ? bn_reg : bd_reg;
                msy = (op_reg == OP_DIV) ? bn_s_reg : bd_s_reg;
            end
        endcase
        prod = DW'(mx) * DW'(my);
    end

    // combine products, or operand a for normalize and negate, into numerator and denominator
    always_comb
    begin
        q1_mag = p_reg[1];
        q1_neg = (op_reg == OP_SUB) ? (ps_reg[1] ^ (p_reg[1] != '0)) : ps_reg[1];
        n_mag  = p_reg[0];
        n_neg  = ps_reg[0];
        d_mag  = p_reg[2];
        d_neg  = ps_reg[2];
        case (op_reg)
            OP_ADD, OP_SUB:
            begin
                if (ps_reg[0] == q1_neg)
                begin
                    n_mag = p_reg[0] + q1_mag;
                    n_neg = ps_reg[0];
                end
                else if (p_reg[0] >= q1_mag)
                begin
                    n_mag = p_reg[0] - q1_mag;
                    n_neg = ps_reg[0];
                end
                else
                begin
                    n_mag = q1_mag - p_reg[0];
                    n_neg = q1_neg;
                end
            end
            OP_MUL, OP_DIV:
            begin
                n_mag = p_reg[0];
                n_neg = ps_reg[0];
            end
            OP_NEG:
            begin
                n_mag = DW'(an_reg);
                n_neg = !an_s_reg;
                d_mag = DW'(ad_reg);
                d_neg = ad_s_reg;
            end
            default:
            begin
                n_mag = DW'(an_reg);
                n_neg = an_s_reg;
                d_mag = DW'(ad_reg);
                d_neg = ad_s_reg;
            end
        endcase
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = nn_reg;
        if (state_reg == S_GCD && u_reg == v_reg)
            div_start = 1'b1;
        else if (state_reg == S_DIVN && div_done)
        begin
            div_start    = 1'b1;
            div_dividend = dd_reg;
        end
    end

    rau_div #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (u_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        ovf  = (div_q > LIMIT - 1'b1)
            || (neg_reg ? (nq_reg > LIMIT) : (nq_reg > LIMIT - 1'b1));
        sval = neg_reg ? signed'(DW'(0) - nq_reg) : signed'(nq_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    if (in_zero)
                        state_next = S_OUT;
                    else if (in_binary)
                        state_next = S_MUL;
                    else
                        state_next = S_COMB;
                end
            S_MUL:
                if (cnt_reg == 2'd2)
                    state_next = S_COMB;
            S_COMB:
                if (d_mag == '0 || n_mag == '0)
                    state_next = S_OUT;
                else
                    state_next = S_GCD;
            S_GCD:
                if (u_reg == v_reg)
                    state_next = S_DIVN;
            S_DIVN:
                if (div_done)
                    state_next = S_DIVD;
            S_DIVD:
                if (div_done)
                    state_next = S_OUT;
            S_OUT:
                if (out_ch.ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_MUL)
                cnt_reg <= (cnt_reg == 2'd2) ? 2'd0 : cnt_reg + 1'b1;
            else
                cnt_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    op_reg   <= in_ch.opcode;
                    an_reg   <= in_an;
                    ad_reg   <= in_ad;
                    bn_reg   <= in_bn;
                    bd_reg   <= in_bd;
                    an_s_reg <= in_ch.a_num[WIDTH-1] && in_an != '0;
                    ad_s_reg <= in_ch.a_den[WIDTH-1];
                    bn_s_reg <= in_ch.b_num[WIDTH-1] && in_bn != '0;
                    bd_s_reg <= in_ch.b_den[WIDTH-1];
                    rnum_reg <= '0;
                    rden_reg <= '0;
                    rst_reg  <= ST_ZERO_DEN;
                end
            S_MUL:
            begin
                p_reg[cnt_reg]  <= prod;
                ps_reg[cnt_reg] <= (prod != '0) && (msx != msy);
            end
            S_COMB:
            begin
                nn_reg  <= n_mag;
                dd_reg  <= d_mag;
                u_reg   <= n_mag;
                v_reg   <= d_mag;
                neg_reg <= n_neg ^ d_neg;
                if (d_mag == '0)
                begin
                    rnum_reg <= '0;
                    rden_reg <= '0;
                    rst_reg  <= ST_ZERO_DEN;
                end
                else
                begin
                    rnum_reg <= '0;
                    rden_reg <= DEN_W'(1);
                    rst_reg  <= ST_OK;
                end
            end
            S_GCD:
                if (u_reg != v_reg)
                begin
                    if (!u_reg[0] && !v_reg[0])
                    begin
                        u_reg  <= u_reg >> 1;
                        v_reg  <= v_reg >> 1;
                        nn_reg <= nn_reg >> 1;
                        dd_reg <= dd_reg >> 1;
                    end
                    else if (!u_reg[0])
                        u_reg <= u_reg >> 1;
                    else if (!v_reg[0])
                        v_reg <= v_reg >> 1;
                    else if (u_reg > v_reg)
                        u_reg <= u_reg - v_reg;
                    else
                        v_reg <= v_reg - u_reg;
                end
            S_DIVN:
                if (div_done)
                    nq_reg <= div_q;
            S_DIVD:
                if (div_done)
                begin
                    if (ovf)
                    begin
                        rnum_reg <= '0;
                        rden_reg <= '0;
                        rst_reg  <= ST_OVERFLOW;
                    end
                    else
                    begin
                        rnum_reg <= FIELD_W'(sval);
                        rden_reg <= DEN_W'(div_q);
                        rst_reg  <= ST_OK;
                    end
                end
            default:
            begin
            end
        endcase
    end

    assign out_ch.valid   = (state_reg == S_OUT);
    assign out_ch.res_num = rnum_reg;
    assign out_ch.res_den = rden_reg;
    assign out_ch.status  = rst_reg;

endmodule
